### src/sstf_disk_request_scheduler_core_defines.svh
// ---------------------------------------------------------------------------
// SSTF scheduler assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define SSTF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define SSTF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SSTF_ASSERT_ALWAYS(label, clk, rst_n, expr)

`define SSTF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define SSTF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/sstf_pkg.sv
// ---------------------------------------------------------------------------
// SSTF scheduler package
// Shared widths, codes, item structs and state encoding.
// ---------------------------------------------------------------------------
package sstf_pkg;

    localparam int TrackW       = 10;
    localparam int IdW          = 4;
    localparam int CountW       = 5;
    localparam int CfgIdxW      = 1;
    localparam int CfgDataW     = 5;
    localparam int IdCount      = 2 ** IdW;
    localparam int SlotsDefault = 16;

    localparam logic [CountW-1:0] QueueLimitReset = CountW'(1);
    localparam logic [CountW-1:0] ReqCountReset   = CountW'(1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_RETIRED = 2'd2
    } t_status;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_RETIRE = 1'b1
    } t_op;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_QUEUE_LIMIT = 1'b0,
        CFG_REQ_COUNT   = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_SERVE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              operation;
        logic [IdW-1:0]    requester_id;
        logic [TrackW-1:0] track;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic              served;
        logic [IdW-1:0]    served_id;
        logic [TrackW-1:0] served_track;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic cmp_en;
    } t_scan_ctl;

    typedef struct packed {
        logic              found;
        logic [TrackW-1:0] track;
    } t_scan_res;

endpackage

### src/sstf_track_ram.sv
// ---------------------------------------------------------------------------
// SSTF track memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sstf_track_ram #(
    parameter int DEPTH = sstf_pkg::IdCount,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [sstf_pkg::TrackW-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [sstf_pkg::TrackW-1:0] o_rdata
);
    import sstf_pkg::*;

    logic [TrackW-1:0] mem [DEPTH];
    logic [TrackW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sstf_nearest.sv
// ---------------------------------------------------------------------------
// SSTF nearest-track tracker
// Takes one slot per cycle while cmp_en is set and keeps the valid slot
// nearest the head; strict less-than keeps the lowest id on a tie.
// ---------------------------------------------------------------------------
module sstf_nearest #(
    parameter int DEPTH = sstf_pkg::IdCount,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sstf_pkg::t_scan_ctl         i_ctl,
    input  logic [AW-1:0]               i_cmp_idx,
    input  logic                        i_slot_valid,
    input  logic [sstf_pkg::TrackW-1:0] i_track,
    input  logic [sstf_pkg::TrackW-1:0] i_head,
    output logic [AW-1:0]               o_best_idx,
    output sstf_pkg::t_scan_res         o_res
);
    import sstf_pkg::*;

    logic              r_found;
    logic [TrackW-1:0] r_best_d;
    logic [AW-1:0]     r_best_idx;
    logic [TrackW-1:0] r_best_trk;
    logic [TrackW-1:0] w_dist;
    logic              w_take;

    assign w_dist = (i_track > i_head) ? (i_track - i_head) : (i_head - i_track);
    assign w_take = i_ctl.cmp_en && i_slot_valid && (!r_found || (w_dist < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_d   <= w_dist;
            r_best_idx <= i_cmp_idx;
            r_best_trk <= i_track;
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_res.found = r_found;
    assign o_res.track = r_best_trk;

endmodule

### src/sstf_disk_request_scheduler_core.sv
// ---------------------------------------------------------------------------
// SSTF disk request scheduler core
// Per-requester slots, nearest-track service with lowest-id tie break.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  in       | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
//  cfg      | input     | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  One item at a time: IDLE, CHECK, SCAN, DRAIN, SERVE, OUT for an item that
//  triggers a serve, with SCAN over DEPTH = min(SLOTS, 16) slots; IDLE, CHECK,
//  OUT otherwise. The serve scan reads one track per cycle from the track
//  memory's single read port.
//  Reset: synchronous, active low; clears slots, flags, counters and head.
//  A stalled output holds the result in the output register; the next item
//  is taken while it waits, and its result waits for the register to free.
// ---------------------------------------------------------------------------
`include "sstf_disk_request_scheduler_core_defines.svh"

module sstf_disk_request_scheduler_core #(
    parameter int SLOTS = sstf_pkg::SlotsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sstf_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sstf_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [sstf_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [sstf_pkg::CfgDataW-1:0] i_cfg_data
);
    import sstf_pkg::*;

    localparam int Depth = (SLOTS < IdCount) ? SLOTS : IdCount;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam logic [8:0]    SlotsW    = 9'(SLOTS);
    localparam logic [AW-1:0] LastIdx   = AW'(Depth - 1);

    t_state            r_state, n_state;
    logic [Depth-1:0]  r_slot_valid, n_slot_valid;
    logic [Depth-1:0]  r_retired, n_retired;
    logic [CountW-1:0] r_ret_count, n_ret_count;
    logic [CountW-1:0] r_pending, n_pending;
    logic [TrackW-1:0] r_head, n_head;
    logic [CountW-1:0] r_queue_limit, n_queue_limit;
    logic [CountW-1:0] r_req_count, n_req_count;
    t_status           r_status, n_status;
    logic              r_served, n_served;
    logic [IdW-1:0]    r_sid, n_sid;
    logic [TrackW-1:0] r_strk, n_strk;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_cmp_en, n_cmp_en;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic [CountW-1:0] w_existing;
    logic [CountW-1:0] w_alive;
    logic [CountW-1:0] w_thresh;
    logic [AW-1:0]     w_id_idx;
    logic              w_known;
    logic              w_we;
    logic              w_re;
    logic [TrackW-1:0] w_rd_track;
    logic [AW-1:0]     w_best_idx;
    t_scan_ctl         w_ctl;
    t_scan_res         w_res;

    always_comb begin
        if ({4'b0, r_req_count} < SlotsW) begin
            w_existing = r_req_count;
        end else begin
            w_existing = CountW'(SLOTS);
        end
        w_alive  = (w_existing > r_ret_count) ? (w_existing - r_ret_count) : '0;
        w_thresh = (w_alive < r_queue_limit) ? w_alive : r_queue_limit;
    end

    assign w_id_idx = AW'(i_in_item.requester_id);
    assign w_known  = ({1'b0, i_in_item.requester_id} < w_existing) && !r_retired[w_id_idx];

    sstf_track_ram #(
        .DEPTH (Depth)
    ) u_track_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_id_idx),
        .i_wdata (i_in_item.track),
        .i_re    (w_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rd_track)
    );

    sstf_nearest #(
        .DEPTH (Depth)
    ) u_nearest (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cmp_idx    (r_cmp_idx),
        .i_slot_valid (r_slot_valid[r_cmp_idx]),
        .i_track      (w_rd_track),
        .i_head       (r_head),
        .o_best_idx   (w_best_idx),
        .o_res        (w_res)
    );

    always_comb begin
        n_state       = r_state;
        n_slot_valid  = r_slot_valid;
        n_retired     = r_retired;
        n_ret_count   = r_ret_count;
        n_pending     = r_pending;
        n_head        = r_head;
        n_queue_limit = r_queue_limit;
        n_req_count   = r_req_count;
        n_status      = r_status;
        n_served      = r_served;
        n_sid         = r_sid;
        n_strk        = r_strk;
        n_rd_idx      = r_rd_idx;
        n_cmp_en      = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_item    = r_out_item;
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_ctl         = '0;
        w_ctl.cmp_en  = r_cmp_en;
        o_in_ready    = 1'b0;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_QUEUE_LIMIT) begin
                n_queue_limit = i_cfg_data;
            end else if (i_cfg_idx == CFG_REQ_COUNT) begin
                n_req_count = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                    priority if (!w_known) begin
                        n_status = ST_RETIRED;
                    end else if (r_slot_valid[w_id_idx]) begin
                        n_status = ST_BUSY;
                    end else if (i_in_item.operation == OP_SUBMIT) begin
                        n_status               = ST_OK;
                        n_slot_valid[w_id_idx] = 1'b1;
                        w_we                   = 1'b1;
                        if (r_pending != '1) begin
                            n_pending = r_pending + CountW'(1);
                        end
                    end else begin
                        n_status            = ST_OK;
                        n_retired[w_id_idx] = 1'b1;
                        if (r_ret_count != '1) begin
                            n_ret_count = r_ret_count + CountW'(1);
                        end
                    end
                end
            end
            S_CHECK: begin
                if ((w_alive != '0) && (r_pending != '0) && (r_pending >= w_thresh)) begin
                    n_rd_idx    = '0;
                    w_ctl.start = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    n_served = 1'b0;
                    n_sid    = '0;
                    n_strk   = '0;
                    n_state  = S_OUT;
                end
            end
            S_SCAN: begin
                w_re      = 1'b1;
                n_cmp_en  = 1'b1;
                n_cmp_idx = r_rd_idx;
                if (r_rd_idx == LastIdx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_SERVE;
            end
            S_SERVE: begin
                if (w_res.found) begin
                    n_served                 = 1'b1;
                    n_sid                    = IdW'(w_best_idx);
                    n_strk                   = w_res.track;
                    n_head                   = w_res.track;
                    n_slot_valid[w_best_idx] = 1'b0;
                    n_pending                = r_pending - CountW'(1);
                end else begin
                    n_served = 1'b0;
                    n_sid    = '0;
                    n_strk   = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_item.status       = r_status;
                    n_out_item.served       = r_served;
                    n_out_item.served_id    = r_sid;
                    n_out_item.served_track = r_strk;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_slot_valid  <= '0;
            r_retired     <= '0;
            r_ret_count   <= '0;
            r_pending     <= '0;
            r_head        <= '0;
            r_queue_limit <= QueueLimitReset;
            r_req_count   <= ReqCountReset;
            r_cmp_en      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_slot_valid  <= n_slot_valid;
            r_retired     <= n_retired;
            r_ret_count   <= n_ret_count;
            r_pending     <= n_pending;
            r_head        <= n_head;
            r_queue_limit <= n_queue_limit;
            r_req_count   <= n_req_count;
            r_cmp_en      <= n_cmp_en;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_served   <= n_served;
        r_sid      <= n_sid;
        r_strk     <= n_strk;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `SSTF_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `SSTF_ASSERT_ALWAYS(a_pending_matches_slots, i_clk, i_rst_n, r_pending == CountW'($countones(r_slot_valid)))
    `SSTF_ASSERT_IMPLIES(a_serve_has_winner, i_clk, i_rst_n, r_state == S_SERVE, w_res.found)

endmodule

### dv/sstf_disk_request_scheduler_core_tb.sv
// ---------------------------------------------------------------------------
// SSTF disk request scheduler core testbench
// Drives submit/retire items through phases of queue limit and requester
// count, predicts status and served slot per item with a scoreboard model,
// and checks every output item in order under random gaps and stalls.
// ---------------------------------------------------------------------------
module sstf_disk_request_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_pkg::*;

    localparam int CycleLimit = 300000;
    localparam int HoldCycles = 400;
    localparam int SettleCycles = 30;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx   = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;

    sstf_disk_request_scheduler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // scheduler state as seen by the scoreboard
    bit                slot_busy [IdCount];
    logic [TrackW-1:0] slot_trk  [IdCount];
    bit                gone      [IdCount];
    int                gone_cnt;
    int                pend_cnt;
    logic [TrackW-1:0] head_trk;
    int                lim_reg;
    int                cnt_reg;

    t_in_item  req_backlog [$];
    t_out_item due_results [$];
    t_out_item oldest;

    int mismatches = 0;
    int cycle_cnt  = 0;
    bit gaps_on    = 1'b1;
    bit hold_armed = 1'b0;
    bit hold_used  = 1'b0;
    int hold_left  = 0;

    function automatic t_out_item schedule_item(t_in_item it);
        t_out_item r;
        int have;
        int live;
        int thresh;
        int best;
        int best_gap;
        int seek_gap;
        r = '0;
        r.status = ST_OK;
        have = (cnt_reg < SlotsDefault) ? cnt_reg : SlotsDefault;
        if (int'(it.requester_id) >= have || gone[it.requester_id]) begin
            r.status = ST_RETIRED;
        end else if (slot_busy[it.requester_id]) begin
            r.status = ST_BUSY;
        end else if (t_op'(it.operation) == OP_SUBMIT) begin
            slot_busy[it.requester_id] = 1'b1;
            slot_trk[it.requester_id] = it.track;
            if (pend_cnt < 31) pend_cnt++;
        end else begin
            gone[it.requester_id] = 1'b1;
            if (gone_cnt < 31) gone_cnt++;
        end
        live = (have > gone_cnt) ? have - gone_cnt : 0;
        thresh = (live < lim_reg) ? live : lim_reg;
        best = -1;
        best_gap = 0;
        if (live > 0 && pend_cnt > 0 && pend_cnt >= thresh) begin
            for (int i = 0; i < IdCount; i++) begin
                if (slot_busy[i]) begin
                    seek_gap = (slot_trk[i] > head_trk) ? int'(slot_trk[i]) - int'(head_trk)
                                                        : int'(head_trk) - int'(slot_trk[i]);
                    if (best < 0 || seek_gap < best_gap) begin
                        best = i;
                        best_gap = seek_gap;
                    end
                end
            end
            if (best >= 0) begin
                r.served = 1'b1;
                r.served_id = IdW'(best);
                r.served_track = slot_trk[best];
                head_trk = slot_trk[best];
                slot_busy[best] = 1'b0;
                pend_cnt--;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (req_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 10)) begin
                i_in_item <= req_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            i_out_ready <= 1'b0;
            hold_left <= HoldCycles;
            hold_used <= 1'b1;
        end else begin
            i_out_ready <= !(gaps_on && $urandom_range(99) < 10);
        end
    end

    // monitor: compare first, then record the newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("item with none due", 0, 0);
                end else begin
                    oldest = due_results.pop_front();
                    if (o_out_item.status !== oldest.status)
                        flag_mismatch("status", int'(o_out_item.status), int'(oldest.status));
                    if (o_out_item.served !== oldest.served)
                        flag_mismatch("served", int'(o_out_item.served), int'(oldest.served));
                    if (o_out_item.served_id !== oldest.served_id)
                        flag_mismatch("served_id", int'(o_out_item.served_id),
                                      int'(oldest.served_id));
                    if (o_out_item.served_track !== oldest.served_track)
                        flag_mismatch("served_track", int'(o_out_item.served_track),
                                      int'(oldest.served_track));
                end
            end
            if (i_in_valid && o_in_ready)
                due_results.push_back(schedule_item(i_in_item));
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_item(t_op op, int id, int trk);
        t_in_item it;
        it.operation = op;
        it.requester_id = IdW'(id);
        it.track = TrackW'(trk);
        req_backlog.push_back(it);
    endtask

    // sampled on the falling edge so the clocked processes have settled
    task automatic settle();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CfgDataW'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_QUEUE_LIMIT) lim_reg = val;
        else cnt_reg = val;
    endtask

    task automatic run_phase(int limit, int reqs, int items, int retire_pct,
                             bit gaps, bit squeeze);
        int span;
        int roll;
        int id;
        int trk;
        settle();
        write_reg(CFG_QUEUE_LIMIT, limit);
        write_reg(CFG_REQ_COUNT, reqs);
        gaps_on = gaps;
        hold_armed = squeeze;
        span = (reqs < SlotsDefault) ? reqs : SlotsDefault;
        for (int n = 0; n < items; n++) begin
            id = ($urandom_range(99) < 90) ? $urandom_range(span - 1) : $urandom_range(15);
            roll = $urandom_range(99);
            if (roll < 60) begin
                trk = $urandom_range(999);
            end else if (roll < 80) begin
                case ($urandom_range(3))
                    0: trk = 0;
                    1: trk = 999;
                    2: trk = 511;
                    default: trk = 512;
                endcase
            end else begin
                trk = 400 + $urandom_range(4);
            end
            if ($urandom_range(99) < retire_pct) add_item(OP_RETIRE, id, trk);
            else add_item(OP_SUBMIT, id, trk);
        end
    endtask

    initial begin
        for (int i = 0; i < IdCount; i++) begin
            slot_busy[i] = 1'b0;
            slot_trk[i] = '0;
            gone[i] = 1'b0;
        end
        gone_cnt = 0;
        pend_cnt = 0;
        head_trk = '0;
        lim_reg = int'(QueueLimitReset);
        cnt_reg = int'(ReqCountReset);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: one requester, serve at once; unknown ids rejected
        add_item(OP_SUBMIT, 0, 999);
        add_item(OP_SUBMIT, 1, 5);
        add_item(OP_RETIRE, 15, 0);
        settle();
        write_reg(CFG_QUEUE_LIMIT, 16);
        write_reg(CFG_REQ_COUNT, 16);
        add_item(OP_SUBMIT, 3, 500);
        add_item(OP_SUBMIT, 0, 0);
        add_item(OP_SUBMIT, 15, 998);
        add_item(OP_SUBMIT, 4, 500);
        add_item(OP_SUBMIT, 3, 7);
        add_item(OP_RETIRE, 3, 0);
        add_item(OP_RETIRE, 7, 0);
        add_item(OP_RETIRE, 7, 0);
        add_item(OP_SUBMIT, 7, 1);
        add_item(OP_SUBMIT, 9, 511);
        add_item(OP_SUBMIT, 8, 512);
        settle();
        // count below retirements: nobody alive, nothing served
        write_reg(CFG_REQ_COUNT, 1);
        add_item(OP_SUBMIT, 0, 3);
        add_item(OP_SUBMIT, 2, 3);
        settle();
        // zero queue limit: drain one per item, ties go to the lower id
        write_reg(CFG_QUEUE_LIMIT, 0);
        write_reg(CFG_REQ_COUNT, 16);
        add_item(OP_SUBMIT, 2, 1);
        add_item(OP_SUBMIT, 15, 0);
        add_item(OP_RETIRE, 12, 0);
        add_item(OP_SUBMIT, 12, 100);
        add_item(OP_SUBMIT, 13, 999);
        add_item(OP_SUBMIT, 14, 1023 - 24);
        add_item(OP_SUBMIT, 11, 0);

        run_phase(16, 16, 300, 0, 1'b1, 1'b0);
        run_phase(1, 16, 200, 0, 1'b0, 1'b0);
        run_phase(4, 8, 250, 0, 1'b1, 1'b1);
        run_phase(8, 31, 250, 0, 1'b1, 1'b0);
        run_phase(0, 12, 150, 0, 1'b1, 1'b0);
        run_phase(16, 16, 300, 3, 1'b1, 1'b0);
        run_phase(2, 16, 160, 1, 1'b1, 1'b0);
        run_phase(1, 2, 40, 2, 1'b1, 1'b0);
        settle();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/sstf_pkg.sv
src/sstf_track_ram.sv
src/sstf_nearest.sv
src/sstf_disk_request_scheduler_core.sv
dv/sstf_disk_request_scheduler_core_tb.sv
